// ----- rtl/svp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_pkg
// Shared constants, types and saturation helper for the velocity predictor.
// ----------------------------------------------------------------------------
package svp_pkg;

	localparam int MAX_GRID_DEF  = 64;
	localparam int FRAC_BITS_DEF = 16;

	localparam int GRID_W = 7;
	localparam int GAIN_W = 31;
	localparam int DATA_W = 32;
	localparam int POS_W  = 6;
	localparam int CFG_W  = 31;

	// configuration register indexes
	localparam logic [1:0] CFG_GRID_SIZE = 2'd0;
	localparam logic [1:0] CFG_DIFF_GAIN = 2'd1;
	localparam logic [1:0] CFG_FORCE_GAIN = 2'd2;
	localparam logic [1:0] CFG_ADV_GAIN  = 2'd3;

	// stencil operands handed to the arithmetic sequencer
	typedef struct packed {
		logic signed [DATA_W-1:0] in_u;
		logic signed [DATA_W-1:0] in_v;
		logic signed [DATA_W-1:0] su;
		logic signed [DATA_W-1:0] sv;
		logic signed [DATA_W-1:0] uc;
		logic signed [DATA_W-1:0] vc;
		logic signed [DATA_W-1:0] ue;
		logic signed [DATA_W-1:0] ve;
		logic signed [DATA_W-1:0] uw;
		logic signed [DATA_W-1:0] vw;
		logic signed [DATA_W-1:0] unw;
		logic signed [DATA_W-1:0] vse;
		logic signed [DATA_W-1:0] fx;
		logic signed [DATA_W-1:0] fy;
	} svp_ops_t;

	typedef struct packed {
		logic [GAIN_W-1:0] diff;
		logic [GAIN_W-1:0] force_g;
		logic [GAIN_W-1:0] adv;
	} svp_gains_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
		logic signed [DATA_W-1:0] r;
		if (x > 64'sh0000_0000_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (x < -64'sh0000_0000_8000_0000)
			r = 32'sh8000_0000;
		else
			r = x[DATA_W-1:0];
		return r;
	endfunction

endpackage

// ----- rtl/staggered_velocity_predictor_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// staggered_velocity_predictor_top
// Momentum predictor on a staggered grid, fed one cell a word in raster order.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       sink       in_valid / in_stall       old_u old_v body_force_x/y prior_u/v
//  out      source     out_valid / out_stall     u_star v_star cell_row cell_col last_cell
//  cfg      sink       cfg_we                    cfg_index cfg_data
//
//  Each cell passes an accept step, a read sweep for the six line-memory reads on
//  the single read port, the shared multiplier sequence and its done flag, then
//  two emit steps, one per possible result, into the output register.
//  A cell is accepted while the previous result still waits in that register.
//  Reset clears counters, control and gains, sets grid 64; memories need no clearing pass.
//  out_stall holds the output register and the emit step behind it.
// ----------------------------------------------------------------------------
module staggered_velocity_predictor_top #(
	parameter int MAX_GRID  = svp_pkg::MAX_GRID_DEF,
	parameter int FRAC_BITS = svp_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [31:0]  old_u,
	input  logic signed [31:0]  old_v,
	input  logic signed [31:0]  body_force_x,
	input  logic signed [31:0]  body_force_y,
	input  logic signed [31:0]  prior_u,
	input  logic signed [31:0]  prior_v,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  u_star,
	output logic signed [31:0]  v_star,
	output logic [5:0]          cell_row,
	output logic [5:0]          cell_col,
	output logic                last_cell,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [svp_pkg::CFG_W-1:0] cfg_data
);
	import svp_pkg::*;

	localparam int CW = $clog2(MAX_GRID);
	localparam int NW = (CW + 1 > GRID_W) ? CW + 1 : GRID_W;
	localparam int AW = $clog2(2 * MAX_GRID);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_READ   = 3'd1;
	localparam logic [2:0] ST_CALC   = 3'd2;
	localparam logic [2:0] ST_EMIT_A = 3'd3;
	localparam logic [2:0] ST_EMIT_B = 3'd4;
	localparam logic [2:0] RD_LAST   = 3'd6;

	logic [2:0]          state_q;
	logic [2:0]          rd_q;
	logic [GRID_W-1:0]   grid_q;
	svp_gains_t          gains_q;
	logic [CW-1:0]       row_q, col_q;
	logic [CW-1:0]       r_item_q, c_item_q;
	svp_ops_t            ops_q;
	logic signed [31:0]  pu_q, pv_q, spu_q, spv_q;

	logic [NW-1:0]       n_eff, g_ext, r_n, c_n, i_n;
	logic                accept, out_free, dp_start, dp_done;
	logic signed [31:0]  comp_u, comp_v;
	logic [CW-1:0]       r_use, c_use;

	// output register
	logic                ov_q, ol_q;
	logic signed [31:0]  ou_q, ovv_q;
	logic [5:0]          orow_q, ocol_q;
	logic                load_a, load_b;

	// clamp the grid size
	assign g_ext = NW'(grid_q);
	always_comb begin
		if (g_ext < NW'(3))
			n_eff = NW'(3);
		else if (g_ext > NW'(MAX_GRID))
			n_eff = NW'(MAX_GRID);
		else
			n_eff = g_ext;
	end

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !ov_q || !out_stall;

	// restart at the origin if the counters left the grid
	always_comb begin
		if (NW'(row_q) >= n_eff || NW'(col_q) >= n_eff) begin
			r_use = '0;
			c_use = '0;
		end else begin
			r_use = row_q;
			c_use = col_q;
		end
	end

	// line memory addressing
	logic [AW:0]    cur_base, prv_base, c_ext, line_sum;
	logic [AW-1:0]  line_addr;
	logic [63:0]    line_rdata;
	logic [127:0]   side_rdata;
	logic           mem_we;

	assign cur_base = r_item_q[0] ? (AW+1)'(MAX_GRID) : '0;
	assign prv_base = r_item_q[0] ? '0 : (AW+1)'(MAX_GRID);
	assign c_ext    = (AW+1)'(c_item_q);
	always_comb begin
		case (rd_q)
			3'd0: line_sum = cur_base + c_ext;
			3'd1: line_sum = prv_base + c_ext;
			3'd2: line_sum = prv_base + c_ext + (AW+1)'(1);
			3'd3: line_sum = prv_base + c_ext - (AW+1)'(1);
			3'd4: line_sum = cur_base + c_ext - (AW+1)'(1);
			3'd5: line_sum = cur_base + c_ext + (AW+1)'(1);
			default: line_sum = cur_base + c_ext;
		endcase
	end
	assign line_addr = line_sum[AW-1:0];
	assign mem_we    = (state_q == ST_READ) && (rd_q == 3'd0);

	svp_ram #(.WIDTH(64), .DEPTH(2 * MAX_GRID)) u_line_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (line_addr),
		.wdata ({ops_q.in_v, ops_q.in_u}),
		.raddr (line_addr),
		.rdata (line_rdata)
	);

	svp_ram #(.WIDTH(128), .DEPTH(MAX_GRID)) u_side_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (c_item_q),
		.wdata ({pv_q, pu_q, ops_q.fy, ops_q.fx}),
		.raddr (c_item_q),
		.rdata (side_rdata)
	);

	assign dp_start = (state_q == ST_READ) && (rd_q == RD_LAST);

	svp_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dp_start),
		.ops    (ops_q),
		.gains  (gains_q),
		.done   (dp_done),
		.comp_u (comp_u),
		.comp_v (comp_v)
	);

	// result selection
	logic in_i, in_j, in_jb;
	logic signed [31:0] ua, va, ub;
	logic [CW-1:0] i_c;
	logic [CW+5:0] pad_ra, pad_rb, pad_c;

	assign r_n = NW'(r_item_q);
	assign c_n = NW'(c_item_q);
	assign i_n = r_n - NW'(1);
	assign i_c = r_item_q - CW'(1);
	assign in_j  = (c_n >= NW'(1)) && (c_n + NW'(2) <= n_eff);
	assign in_i  = (i_n >= NW'(1)) && (i_n + NW'(2) <= n_eff);
	assign in_jb = in_j;

	always_comb begin
		ua = spu_q;
		va = spv_q;
		if (in_j && (i_n == NW'(1) || i_n == n_eff - NW'(1)))
			ua = '0;
		if (in_i && (c_n == NW'(1) || c_n == n_eff - NW'(1)))
			va = '0;
		if (in_i && in_j) begin
			if (i_n >= NW'(2))
				ua = comp_u;
			if (c_n >= NW'(2))
				va = comp_v;
		end
		ub = in_jb ? 32'sd0 : pu_q;
	end

	assign pad_ra = {6'b0, i_c};
	assign pad_rb = {6'b0, r_item_q};
	assign pad_c  = {6'b0, c_item_q};

	// load the output register from either emit step
	assign load_a = (state_q == ST_EMIT_A) && (r_item_q != '0) && out_free;
	assign load_b = (state_q == ST_EMIT_B) && (r_n == n_eff - NW'(1)) && out_free;

	// configuration registers and frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q  <= GRID_W'(64);
			gains_q <= '0;
			row_q   <= '0;
			col_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRID_SIZE: begin
					grid_q <= cfg_data[GRID_W-1:0];
					row_q  <= '0;
					col_q  <= '0;
				end
				CFG_DIFF_GAIN:  gains_q.diff    <= cfg_data[GAIN_W-1:0];
				CFG_FORCE_GAIN: gains_q.force_g <= cfg_data[GAIN_W-1:0];
				CFG_ADV_GAIN:   gains_q.adv     <= cfg_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end else if (accept) begin
			// advance in raster order
			if (NW'(c_use) + NW'(1) >= n_eff) begin
				col_q <= '0;
				if (NW'(r_use) + NW'(1) >= n_eff)
					row_q <= '0;
				else
					row_q <= r_use + CW'(1);
			end else begin
				col_q <= c_use + CW'(1);
				row_q <= r_use;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_q    <= '0;
			ov_q    <= 1'b0;
		end else begin
			ov_q <= (ov_q && out_stall) || load_a || load_b;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_READ;
						rd_q    <= '0;
					end
				end
				ST_READ: begin
					if (rd_q == RD_LAST)
						state_q <= ST_CALC;
					else
						rd_q <= rd_q + 3'd1;
				end
				ST_CALC: begin
					if (dp_done)
						state_q <= ST_EMIT_A;
				end
				ST_EMIT_A: begin
					if (r_item_q == '0)
						state_q <= ST_EMIT_B;
					else if (out_free)
						state_q <= ST_EMIT_B;
				end
				ST_EMIT_B: begin
					if (r_n != n_eff - NW'(1))
						state_q <= ST_IDLE;
					else if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (accept) begin
			r_item_q  <= r_use;
			c_item_q  <= c_use;
			ops_q.in_u <= old_u;
			ops_q.in_v <= old_v;
			ops_q.fx   <= body_force_x;
			ops_q.fy   <= body_force_y;
			pu_q       <= prior_u;
			pv_q       <= prior_v;
		end
		if (state_q == ST_READ) begin
			case (rd_q)
				3'd1: begin
					ops_q.su <= line_rdata[31:0];
					ops_q.sv <= line_rdata[63:32];
					ops_q.fx <= side_rdata[31:0];
					ops_q.fy <= side_rdata[63:32];
					spu_q    <= side_rdata[95:64];
					spv_q    <= side_rdata[127:96];
				end
				3'd2: begin
					ops_q.uc <= line_rdata[31:0];
					ops_q.vc <= line_rdata[63:32];
				end
				3'd3: begin
					ops_q.ue <= line_rdata[31:0];
					ops_q.ve <= line_rdata[63:32];
				end
				3'd4: begin
					ops_q.uw <= line_rdata[31:0];
					ops_q.vw <= line_rdata[63:32];
				end
				3'd5: ops_q.unw <= line_rdata[31:0];
				3'd6: ops_q.vse <= line_rdata[63:32];
				default: begin
				end
			endcase
		end
		// load the output word
		if (load_a) begin
			ou_q   <= ua;
			ovv_q  <= va;
			orow_q <= pad_ra[5:0];
			ocol_q <= pad_c[5:0];
			ol_q   <= 1'b0;
		end else if (load_b) begin
			ou_q   <= ub;
			ovv_q  <= pv_q;
			orow_q <= pad_rb[5:0];
			ocol_q <= pad_c[5:0];
			ol_q   <= (c_n == n_eff - NW'(1));
		end
	end

	assign out_valid = ov_q;
	assign u_star    = ou_q;
	assign v_star    = ovv_q;
	assign cell_row  = orow_q;
	assign cell_col  = ocol_q;
	assign last_cell = ol_q;

`ifndef SYNTH
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_READ && rd_q == 3'd0))
		else $error("accepted word did not start the read sweep");
	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		dp_done |-> state_q == ST_CALC)
		else $error("arithmetic finished outside the compute phase");
	a_counters_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		##1 (NW'(row_q) < n_eff && NW'(col_q) < n_eff))
		else $error("frame counters left the grid");
	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == ST_EMIT_A || $past(state_q) == ST_EMIT_B))
		else $error("output word loaded outside an emit step");
`endif

endmodule

// ----- rtl/svp_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_ram
// Simple dual-port synchronous RAM, one write and one registered read.
// ----------------------------------------------------------------------------
module svp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// read port, old data on a same-address write
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/svp_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_datapath
// Sequenced fixed-point arithmetic: one shared multiplier, then accumulate.
// ----------------------------------------------------------------------------
module svp_datapath #(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  svp_pkg::svp_ops_t     ops,
	input  svp_pkg::svp_gains_t   gains,
	output logic                  done,
	output logic signed [31:0]    comp_u,
	output logic signed [31:0]    comp_v
);
	import svp_pkg::*;

	localparam logic [4:0] S_LAST = 5'd17;

	logic             busy_q;
	logic [4:0]       step_q;
	logic             done_q;

	logic signed [31:0] lap_u_q, lap_v_q, dnu_q, deu_q, dnv_q, dev_q, ubar_q, vbar_q;
	logic signed [31:0] m0_q, m1_q, m2_q, m3_q, m4_q, m5_q, m6_q, m7_q;
	logic signed [31:0] tu_q, tv_q, cu_q, cv_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] mul_a, mul_b, mres;
	logic signed [63:0] lap_u, lap_v, sum_ub, sum_vb;
	logic signed [31:0] gd, gf, ga;

	assign gd = $signed({1'b0, gains.diff});
	assign gf = $signed({1'b0, gains.force_g});
	assign ga = $signed({1'b0, gains.adv});

	// stencil sums
	assign lap_u = 64'(ops.in_u) + 64'(ops.su) + 64'(ops.ue) + 64'(ops.uw)
		- (64'(ops.uc) <<< 2);
	assign lap_v = 64'(ops.in_v) + 64'(ops.sv) + 64'(ops.ve) + 64'(ops.vw)
		- (64'(ops.vc) <<< 2);
	assign sum_ub = 64'(ops.uc) + 64'(ops.in_u) + 64'(ops.unw) + 64'(ops.uw);
	assign sum_vb = 64'(ops.vc) + 64'(ops.sv) + 64'(ops.vse) + 64'(ops.ve);

	// select multiplier operands for this step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			5'd1:  begin mul_a = gd;   mul_b = lap_u_q; end
			5'd2:  begin mul_a = gf;   mul_b = ops.fx;  end
			5'd3:  begin mul_a = ga;   mul_b = ops.uc;  end
			5'd4:  begin mul_a = ga;   mul_b = vbar_q;  end
			5'd5:  begin mul_a = gd;   mul_b = lap_v_q; end
			5'd6:  begin mul_a = gf;   mul_b = ops.fy;  end
			5'd7:  begin mul_a = ga;   mul_b = ubar_q;  end
			5'd8:  begin mul_a = ga;   mul_b = ops.vc;  end
			5'd9:  begin mul_a = m2_q; mul_b = dnu_q;   end
			5'd10: begin mul_a = m3_q; mul_b = deu_q;   end
			5'd11: begin mul_a = m6_q; mul_b = dnv_q;   end
			5'd12: begin mul_a = m7_q; mul_b = dev_q;   end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// floor shift and saturate the registered product
	assign mres = sat32(prod_q >>> FRAC_BITS);

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == S_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					step_q <= '0;
				end else begin
					step_q <= step_q + 5'd1;
				end
			end
		end
	end

	// arithmetic registers
	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
		if (busy_q) begin
			case (step_q)
				5'd0: begin
					lap_u_q <= sat32(lap_u);
					lap_v_q <= sat32(lap_v);
					dnu_q   <= sat32(64'(ops.in_u) - 64'(ops.su));
					deu_q   <= sat32(64'(ops.ue) - 64'(ops.uw));
					dnv_q   <= sat32(64'(ops.in_v) - 64'(ops.sv));
					dev_q   <= sat32(64'(ops.ve) - 64'(ops.vw));
					ubar_q  <= 32'(sum_ub >>> 2);
					vbar_q  <= 32'(sum_vb >>> 2);
				end
				5'd2:  m0_q <= mres;
				5'd3:  m1_q <= mres;
				5'd4:  m2_q <= mres;
				5'd5:  m3_q <= mres;
				5'd6:  m4_q <= mres;
				5'd7:  m5_q <= mres;
				5'd8:  m6_q <= mres;
				5'd9:  m7_q <= mres;
				5'd10: m2_q <= mres;
				5'd11: m3_q <= mres;
				5'd12: m6_q <= mres;
				5'd13: m7_q <= mres;
				5'd14: begin
					tu_q <= sat32(64'(m0_q) + 64'(m1_q));
					tv_q <= sat32(64'(m4_q) + 64'(m5_q));
				end
				5'd15: begin
					tu_q <= sat32(64'(tu_q) - 64'(m2_q));
					tv_q <= sat32(64'(tv_q) - 64'(m6_q));
				end
				5'd16: begin
					tu_q <= sat32(64'(tu_q) - 64'(m3_q));
					tv_q <= sat32(64'(tv_q) - 64'(m7_q));
				end
				5'd17: begin
					cu_q <= sat32(64'(tu_q) + 64'(ops.uc));
					cv_q <= sat32(64'(tv_q) + 64'(ops.vc));
				end
				default: begin
				end
			endcase
		end
	end

	assign done   = done_q;
	assign comp_u = cu_q;
	assign comp_v = cv_q;

endmodule

// ----- tb/staggered_velocity_predictor_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// staggered_velocity_predictor_top_test
// Feeds grid frames of random and corner-case cells into the velocity
// predictor, predicts every emitted cell in a scoreboard of its own, and
// checks each output word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module staggered_velocity_predictor_top_test;

	import svp_pkg::*;

	localparam int GRID_MAX   = 64;
	localparam int FRAC       = 16;
	localparam int ITEM_GOAL  = 850;
	localparam int STALL_MAX  = 6;
	localparam int DRAIN_WAIT = 40;
	localparam int HANG_LIMIT = 1000;

	typedef struct {
		int          u;
		int          v;
		int unsigned row;
		int unsigned col;
		bit          last;
	} cell_word_t;

	typedef struct {
		int ou, ov, fx, fy, pu, pv;
	} cell_in_t;

	// ------------------------------------------------------------------
	// Scoreboard: own copy of line stores, counters and gains
	// ------------------------------------------------------------------
	class velocity_scoreboard;
		cell_word_t  pending[$];
		int          errors;
		int          u_rows[2*GRID_MAX];
		int          v_rows[2*GRID_MAX];
		int          side[GRID_MAX][4];
		int unsigned row_cnt, col_cnt;
		int unsigned grid, dgain, fgain, again;

		function new();
			errors  = 0;
			row_cnt = 0;
			col_cnt = 0;
			grid    = 64;
			dgain   = 0;
			fgain   = 0;
			again   = 0;
			foreach (u_rows[k]) begin
				u_rows[k] = 0;
				v_rows[k] = 0;
			end
			foreach (side[k]) for (int m = 0; m < 4; m++) side[k][m] = 0;
		endfunction

		function int sat(longint x);
			if (x > 64'sh7FFF_FFFF)
				return 32'sh7FFF_FFFF;
			if (x < -64'sh8000_0000)
				return 32'sh8000_0000;
			return int'(x);
		endfunction

		// flooring Q16.16 product
		function int qmul(longint a, longint b);
			return sat((a * b) >>> FRAC);
		endfunction

		function int unsigned grid_n();
			if (grid < 3) return 3;
			if (grid > GRID_MAX) return GRID_MAX;
			return grid;
		endfunction

		function int momentum(int c, int n, int s, int e, int w, int f, int avg,
				int dn, int de, bit along_u);
			longint lap;
			longint t;
			int a1, a2;
			lap = longint'(n) + s + e + w - 4 * longint'(c);
			t = longint'(qmul(dgain, sat(lap))) + qmul(fgain, f);
			t = sat(t);
			if (along_u) begin
				a1 = qmul(qmul(again, c), dn);
				a2 = qmul(qmul(again, avg), de);
			end else begin
				a1 = qmul(qmul(again, avg), dn);
				a2 = qmul(qmul(again, c), de);
			end
			t = sat(t - a1);
			t = sat(t - a2);
			return sat(t + c);
		endfunction

		function void apply_cfg(logic [1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				CFG_GRID_SIZE: begin
					grid    = val[GRID_W-1:0];
					row_cnt = 0;
					col_cnt = 0;
				end
				CFG_DIFF_GAIN:  dgain = val;
				CFG_FORCE_GAIN: fgain = val;
				CFG_ADV_GAIN:   again = val;
				default: begin
				end
			endcase
		endfunction

		function void note_cell(cell_in_t x);
			int unsigned n, r, c, cur, prv, i, j;
			int su, sv, sfx, sfy, spu, spv, us, vs;
			int uc, vc, ue, ve, uw, vw, unw, vse, ubar, vbar;
			bit in_i, in_j;
			cell_word_t w;
			n = grid_n();
			r = row_cnt;
			c = col_cnt;
			if (r >= n || c >= n) begin
				r = 0;
				c = 0;
			end
			cur = (r & 1) * GRID_MAX;
			prv = ((r + 1) & 1) * GRID_MAX;
			su  = u_rows[cur+c];
			sv  = v_rows[cur+c];
			sfx = side[c][0];
			sfy = side[c][1];
			spu = side[c][2];
			spv = side[c][3];
			u_rows[cur+c] = x.ou;
			v_rows[cur+c] = x.ov;
			side[c][0] = x.fx;
			side[c][1] = x.fy;
			side[c][2] = x.pu;
			side[c][3] = x.pv;

			// row above is complete at this column: emit it
			if (r >= 1) begin
				i = r - 1;
				j = c;
				us = spu;
				vs = spv;
				in_j = (j >= 1 && j + 2 <= n);
				in_i = (i >= 1 && i + 2 <= n);
				if (in_j && (i == 1 || i == n - 1)) us = 0;
				if (in_i && (j == 1 || j == n - 1)) vs = 0;
				if (in_i && in_j) begin
					uc  = u_rows[prv+j];
					vc  = v_rows[prv+j];
					ue  = u_rows[prv+j+1];
					ve  = v_rows[prv+j+1];
					uw  = u_rows[prv+j-1];
					vw  = v_rows[prv+j-1];
					unw = u_rows[cur+j-1];
					vse = v_rows[cur+j+1];
					ubar = int'((longint'(uc) + x.ou + unw + uw) >>> 2);
					vbar = int'((longint'(vc) + sv + vse + ve) >>> 2);
					if (i >= 2)
						us = momentum(uc, x.ou, su, ue, uw, sfx, vbar,
							sat(longint'(x.ou) - su), sat(longint'(ue) - uw), 1'b1);
					if (j >= 2)
						vs = momentum(vc, x.ov, sv, ve, vw, sfy, ubar,
							sat(longint'(x.ov) - sv), sat(longint'(ve) - vw), 1'b0);
				end
				w = '{u: us, v: vs, row: i & 63, col: j & 63, last: 1'b0};
				pending.push_back(w);
			end

			// last row goes out with its own input
			if (r == n - 1) begin
				us = x.pu;
				if (c >= 1 && c + 2 <= n) us = 0;
				w = '{u: us, v: x.pv, row: r & 63, col: c & 63, last: (c == n - 1)};
				pending.push_back(w);
			end

			c++;
			if (c >= n) begin
				c = 0;
				r++;
				if (r >= n) r = 0;
			end
			row_cnt = r;
			col_cnt = c;
		endfunction

		function void check_cell(cell_word_t act);
			cell_word_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word u=%h v=%h row=%0d col=%0d last=%0d",
					$time, act.u, act.v, act.row, act.col, act.last);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (e.u !== act.u) begin
				$display("%0t: u_star exp %h act %h", $time, e.u, act.u);
				errors++;
			end
			if (e.v !== act.v) begin
				$display("%0t: v_star exp %h act %h", $time, e.v, act.v);
				errors++;
			end
			if (e.row !== act.row) begin
				$display("%0t: cell_row exp %0d act %0d", $time, e.row, act.row);
				errors++;
			end
			if (e.col !== act.col) begin
				$display("%0t: cell_col exp %0d act %0d", $time, e.col, act.col);
				errors++;
			end
			if (e.last !== act.last) begin
				$display("%0t: last_cell exp %0d act %0d", $time, e.last, act.last);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic signed [31:0] old_u, old_v, body_force_x, body_force_y, prior_u, prior_v;
	logic              out_valid;
	logic              out_stall;
	logic signed [31:0] u_star, v_star;
	logic [5:0]        cell_row, cell_col;
	logic              last_cell;
	logic              cfg_we;
	logic [1:0]        cfg_index;
	logic [CFG_W-1:0]  cfg_data;

	velocity_scoreboard sb;
	bit  in_gaps;
	bit  out_gaps;
	int  sent;
	int  hang_cnt;

	staggered_velocity_predictor_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.old_u(old_u), .old_v(old_v),
		.body_force_x(body_force_x), .body_force_y(body_force_y),
		.prior_u(prior_u), .prior_v(prior_v),
		.out_valid(out_valid), .out_stall(out_stall),
		.u_star(u_star), .v_star(v_star),
		.cell_row(cell_row), .cell_col(cell_col), .last_cell(last_cell),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// stop a hung run
	always @(negedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			hang_cnt = 0;
		else
			hang_cnt++;
		if (hang_cnt >= HANG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// draw a data word: corners, small Q16.16 values or raw bits
	function automatic int pick_word(int mode);
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (mode == 1 || sel == 0) begin
			case ($urandom_range(0, 4))
				0: return 32'sh7FFF_FFFF;
				1: return 32'sh8000_0000;
				2: return 0;
				3: return -1;
				default: return 32'sh0001_0000;
			endcase
		end
		if (sel < 7)
			return int'($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
		return int'($urandom);
	endfunction

	function automatic int unsigned pick_gain();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 31'h7FFF_FFFF;
			2: return $urandom & 32'h7FFF_FFFF;
			default: return $urandom_range(0, 32'h0002_0000);
		endcase
	endfunction

	task automatic write_reg(logic [1:0] idx, int unsigned val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_W-1:0];
		sb.apply_cfg(idx, val[CFG_W-1:0]);
		@(posedge clk);
	endtask

	// wait for the pipe to empty, then reprogram all registers
	task automatic setup_phase(int unsigned n, int unsigned dg, int unsigned fg,
			int unsigned ag);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		write_reg(CFG_GRID_SIZE, n);
		write_reg(CFG_DIFF_GAIN, dg);
		write_reg(CFG_FORCE_GAIN, fg);
		write_reg(CFG_ADV_GAIN, ag);
		cfg_we <= 1'b0;
	endtask

	// present one cell word and hold it until accepted
	task automatic send_cell(int mode);
		cell_in_t x;
		int unsigned gap;
		x.ou = pick_word(mode);
		x.ov = pick_word(mode);
		x.fx = pick_word(mode);
		x.fy = pick_word(mode);
		x.pu = pick_word(mode);
		x.pv = pick_word(mode);
		gap = in_gaps ? $urandom_range(0, STALL_MAX) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		old_u        <= x.ou;
		old_v        <= x.ov;
		body_force_x <= x.fx;
		body_force_y <= x.fy;
		prior_u      <= x.pu;
		prior_v      <= x.pv;
		do @(negedge clk); while (in_stall);
		sb.note_cell(x);
		@(posedge clk);
		sent++;
	endtask

	task automatic run_phase(int unsigned n, int unsigned dg, int unsigned fg,
			int unsigned ag, int cells, int mode);
		setup_phase(n, dg, fg, ag);
		repeat (cells) send_cell(mode);
		in_valid <= 1'b0;
	endtask

	// output side: random stall, sample accepted words at the falling edge
	initial begin
		cell_word_t got;
		int unsigned k;
		@(posedge arst_n);
		forever begin
			k = out_gaps ? $urandom_range(0, STALL_MAX) : 0;
			if (k != 0) begin
				out_stall <= 1'b1;
				repeat (k) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(negedge clk); while (!out_valid);
			got = '{u: u_star, v: v_star, row: cell_row, col: cell_col, last: last_cell};
			sb.check_cell(got);
			@(posedge clk);
		end
	end

	initial begin
		int unsigned n;
		int          cells;
		sb = new();
		sent     = 0;
		hang_cnt = 0;
		in_gaps  = 1'b1;
		out_gaps = 1'b1;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		out_stall    <= 1'b0;
		old_u        <= '0;
		old_v        <= '0;
		body_force_x <= '0;
		body_force_y <= '0;
		prior_u      <= '0;
		prior_v      <= '0;
		cfg_we       <= 1'b0;
		cfg_index    <= CFG_GRID_SIZE;
		cfg_data     <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: undersized grid acting as 3, then 4, both with full-scale gains
		run_phase(0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 9, 1);
		run_phase(4, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16, 1);

		// random frames, mostly small grids, some undersized, a few full-size or oversized partial ones
		while (sent < ITEM_GOAL) begin
			in_gaps  = ($urandom_range(0, 3) != 0);
			out_gaps = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 11))
				0: begin
					n = $urandom_range(0, 2);
					cells = 9 * $urandom_range(1, 2);
				end
				1: begin
					n = ($urandom_range(0, 1) != 0) ? 64 : $urandom_range(65, 127);
					cells = $urandom_range(64, 200);
				end
				2: begin
					n = $urandom_range(3, 8);
					cells = $urandom_range(1, n * n);
				end
				default: begin
					n = $urandom_range(3, 8);
					cells = n * n * $urandom_range(1, 2);
				end
			endcase
			run_phase(n, pick_gain(), pick_gain(), pick_gain(), cells, 0);
		end

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/svp_pkg.sv
rtl/svp_ram.sv
rtl/svp_datapath.sv
rtl/staggered_velocity_predictor_top.sv
tb/staggered_velocity_predictor_top_test.sv
